### design/pple_pkg.sv
// ----------------------------------------------------------------------------
// pple_pkg
// Shared sizes, register indexes and controller states of the particle pool.
// ----------------------------------------------------------------------------
package pple_pkg;

   localparam int MAX_PARTICLES = 64;
   localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

   localparam int TIME_W = 32;
   localparam int LIFE_W = 31;
   localparam int ACC_W  = 33;
   localparam int OUT_W  = 7;

   localparam logic [31:0] SPAWN_INTERVAL_RST   = 32'd200000;
   localparam logic [30:0] DEFAULT_LIFETIME_RST = 31'd5000000;

   typedef enum logic [1:0] {
      REG_SPAWN_INTERVAL   = 2'd0,
      REG_DEFAULT_LIFETIME = 2'd1,
      REG_PAUSED           = 2'd2,
      REG_EMITTER_ENABLED  = 2'd3
   } reg_index_type;

   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_SPAWN,
      ST_DONE
   } state_type;

endpackage

### design/particle_pool_lifetime_emitter_top.sv
// ----------------------------------------------------------------------------
// particle_pool_lifetime_emitter_top
// Particle slot pool with lifetime expiry and an interval spawner.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one item per transfer. req_tuser is the op (tick or clear),
//            req_tdata the elapsed time of a tick in microseconds.
//   rsp_*  : one result per item: live count, spawned, expired, pool full.
//   csr_*  : register writes (index, data); ready out of reset, write only
//            while idle.
// Timing:
//   A clear or a paused tick passes through ST_DONE into the output register.
//   A running tick sweeps the lifetime memory, one slot a cycle, through a
//   registered read, while the spawn division (one quotient bit a cycle)
//   runs beside it. Then the spawn pass walks slots from the lowest up
//   until the spawn count is used or the last slot is passed.
//   One item is in work at a time; the next is taken once the result is
//   in the output register.
// Reset: all slots free, accumulator zero, registers at their defaults.
//   No clearing pass: lifetimes are only used for live slots.
// Stall: a result waits in the output register; the next item may be taken
//   and worked on, and its result holds in the controller until rsp frees.
// ----------------------------------------------------------------------------
module particle_pool_lifetime_emitter_top
   import pple_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] elapsed
   input  logic        req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [6:0] active_count, [13:7] spawned,
                                    // [20:14] expired, [21] all_active, rest 0
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam logic [IDX_W:0] IDX_END = (IDX_W + 1)'(MAX_PARTICLES);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PARTICLES);

   // configuration
   logic [31:0]        interval_ff;
   logic [LIFE_W-1:0]  lifetime_ff;
   logic               paused_ff;
   logic               enabled_ff;

   // control
   state_type          state_ff, state_in;
   logic [IDX_W:0]     idx_ff;
   logic               rd_valid_ff;
   logic [IDX_W-1:0]   rd_addr_ff;
   logic [MAX_PARTICLES-1:0] live_ff;
   logic [CNT_W-1:0]   live_cnt_ff;
   logic [CNT_W-1:0]   expired_ff;
   logic [CNT_W-1:0]   spawned_ff;
   logic [CNT_W-1:0]   spawn_left_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [TIME_W-1:0]  elapsed_ff;
   logic               rsp_valid_ff;
   logic [23:0]        rsp_data_ff;

   // divider
   logic [5:0]         div_cnt_ff;
   logic [31:0]        div_iv_ff;
   logic [31:0]        div_rem_ff;
   logic [ACC_W-1:0]   div_quo_ff;

   // lifetime memory
   logic [LIFE_W-1:0]  mem [MAX_PARTICLES];
   logic [LIFE_W-1:0]  mem_q;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [LIFE_W-1:0]  mem_wdata;
   logic               rd_en;

   logic               req_xfer, out_free, tick_run;
   logic               sweep_done, spawn_done;
   logic               slot_expire;
   logic [ACC_W:0]     acc_sum;
   logic [ACC_W-1:0]   acc_sat;
   logic [31:0]        iv_eff;
   logic               acc_gt;
   logic [ACC_W-1:0]   div_t;
   logic               div_ge;
   logic [CNT_W-1:0]   free_cnt;
   logic [CNT_W-1:0]   spawn_take;
   logic               spawn_hit;
   logic [CNT_W+OUT_W-1:0] act_x, spn_x, exp_x;

   assign csr_ready = !reset;
   assign req_xfer  = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign tick_run  = (op_type'(req_tuser) == OP_TICK) && !paused_ff;

   assign acc_sum = {1'b0, acc_ff} + {2'b00, req_tdata};
   assign acc_sat = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
   assign iv_eff  = (interval_ff == 32'd0) ? 32'd1 : interval_ff;
   assign acc_gt  = acc_sat > {1'b0, iv_eff};

   assign sweep_done  = (idx_ff == IDX_END) && !rd_valid_ff;
   assign spawn_done  = (spawn_left_ff == '0) || (idx_ff == IDX_END);
   assign slot_expire = {1'b0, mem_q} <= elapsed_ff;
   assign spawn_hit   = (state_ff == ST_SPAWN) && !spawn_done
                        && !live_ff[idx_ff[IDX_W-1:0]];

   assign div_t  = {div_rem_ff, div_quo_ff[ACC_W-1]};
   assign div_ge = div_t >= {1'b0, div_iv_ff};

   assign free_cnt   = CNT_MAX - live_cnt_ff;
   assign spawn_take = (div_quo_ff >= ACC_W'(free_cnt)) ? free_cnt
                                                        : div_quo_ff[CNT_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = tick_run ? ST_SWEEP : ST_DONE;
            end
         end
         ST_SWEEP: begin
            if (sweep_done && (div_cnt_ff == '0)) begin
               state_in = ST_SPAWN;
            end
         end
         ST_SPAWN: begin
            if (spawn_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the controller
   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = rd_addr_ff;
      mem_wdata  = mem_q - elapsed_ff[LIFE_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = !reset;
         end
         ST_SWEEP: begin
            rd_en  = idx_ff != IDX_END;
            mem_we = rd_valid_ff && live_ff[rd_addr_ff] && !slot_expire;
         end
         ST_SPAWN: begin
            mem_we    = spawn_hit;
            mem_waddr = idx_ff[IDX_W-1:0];
            mem_wdata = lifetime_ff;
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_q <= mem[idx_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= SPAWN_INTERVAL_RST;
         lifetime_ff <= DEFAULT_LIFETIME_RST;
         paused_ff   <= 1'b0;
         enabled_ff  <= 1'b1;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_SPAWN_INTERVAL:   interval_ff <= csr_data;
            REG_DEFAULT_LIFETIME: lifetime_ff <= csr_data[LIFE_W-1:0];
            REG_PAUSED:           paused_ff   <= csr_data[0];
            REG_EMITTER_ENABLED:  enabled_ff  <= csr_data[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         live_ff       <= '0;
         live_cnt_ff   <= '0;
         expired_ff    <= '0;
         spawned_ff    <= '0;
         spawn_left_ff <= '0;
         acc_ff        <= '0;
         div_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= rd_en;

         if (req_xfer) begin
            idx_ff     <= '0;
            expired_ff <= '0;
            spawned_ff <= '0;
            div_quo_ff <= '0;
            if (op_type'(req_tuser) == OP_CLEAR) begin
               live_ff     <= '0;
               live_cnt_ff <= '0;
            end else if (tick_run && enabled_ff) begin
               if (acc_gt) begin
                  div_cnt_ff <= 6'(ACC_W);
                  div_quo_ff <= acc_sat - ACC_W'(1);
               end else begin
                  acc_ff <= acc_sat;
               end
            end
         end

         if (div_cnt_ff != '0) begin
            div_cnt_ff <= div_cnt_ff - 6'd1;
            div_quo_ff <= {div_quo_ff[ACC_W-2:0], div_ge};
            if (div_cnt_ff == 6'd1) begin
               acc_ff <= {1'b0, div_ge ? div_t[31:0] - div_iv_ff : div_t[31:0]}
                         + ACC_W'(1);
            end
         end

         if (state_ff == ST_SWEEP) begin
            if (rd_en) begin
               idx_ff <= idx_ff + 1'b1;
            end
            if (rd_valid_ff && live_ff[rd_addr_ff] && slot_expire) begin
               live_ff[rd_addr_ff] <= 1'b0;
               live_cnt_ff         <= live_cnt_ff - 1'b1;
               expired_ff          <= expired_ff + 1'b1;
            end
            if (state_in == ST_SPAWN) begin
               idx_ff        <= '0;
               spawn_left_ff <= spawn_take;
            end
         end

         if ((state_ff == ST_SPAWN) && !spawn_done) begin
            idx_ff <= idx_ff + 1'b1;
            if (spawn_hit) begin
               live_ff[idx_ff[IDX_W-1:0]] <= 1'b1;
               live_cnt_ff   <= live_cnt_ff + 1'b1;
               spawned_ff    <= spawned_ff + 1'b1;
               spawn_left_ff <= spawn_left_ff - 1'b1;
            end
         end

         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   assign act_x = {{OUT_W{1'b0}}, live_cnt_ff};
   assign spn_x = {{OUT_W{1'b0}}, spawned_ff};
   assign exp_x = {{OUT_W{1'b0}}, expired_ff};

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         elapsed_ff <= req_tdata;
         div_iv_ff  <= iv_eff;
         div_rem_ff <= '0;
      end else if (div_cnt_ff != '0) begin
         div_rem_ff <= div_ge ? div_t[31:0] - div_iv_ff : div_t[31:0];
      end
      if (rd_en) begin
         rd_addr_ff <= idx_ff[IDX_W-1:0];
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_data_ff <= {2'b00, live_cnt_ff >= CNT_MAX, exp_x[OUT_W-1:0],
                         spn_x[OUT_W-1:0], act_x[OUT_W-1:0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_live_count : assert property (@(posedge clock) disable iff (reset)
      live_cnt_ff == CNT_W'($countones(live_ff)))
      else $error("live count out of step with live bits");

   a_div_before_spawn : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPAWN) |-> (div_cnt_ff == '0))
      else $error("spawn pass started before division finished");

   a_spawn_fits : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPAWN) |->
         ({1'b0, spawn_left_ff} + {1'b0, live_cnt_ff} <= {1'b0, CNT_MAX}))
      else $error("spawn count exceeds free slots");

   a_write_in_pass : assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == ST_SWEEP) || (state_ff == ST_SPAWN)))
      else $error("lifetime write outside sweep or spawn pass");
`endif

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Particle pool checker. Ticks and clears go in over req_*. Register settings
// change only between items or phases, while the pool is idle. Every accepted item is
// run through a cycle-free pool model kept here. Each rsp_* transfer is
// compared field by field with the oldest predicted count set.
// ----------------------------------------------------------------------------
module testbench;
   import pple_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 10;
   localparam int ITEM_TARGET  = 1950;
   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_LIMIT   = 4000;
   localparam int TAIL_CYCLES  = 150;
   localparam int NUM_ROWS     = 28;
   localparam logic [63:0] ACC_CEIL = 64'h1_FFFF_FFFF;
   localparam reg_index_type NO_REG = REG_SPAWN_INTERVAL;

   typedef struct packed {
      logic [1:0]       pad;
      logic             all_active;
      logic [OUT_W-1:0] expired;
      logic [OUT_W-1:0] spawned;
      logic [OUT_W-1:0] active_count;
   } pool_result_type;

   typedef enum logic { ROW_ITEM, ROW_REG } row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      reg_index_type    index;
      op_type           op;
      logic [31:0]      arg;          // register value or elapsed time
      logic             typed;
      logic [OUT_W-1:0] want_active;
      logic [OUT_W-1:0] want_spawned;
      logic [OUT_W-1:0] want_expired;
      logic             want_full;
   } plan_row_type;

   typedef struct packed {
      logic            typed;
      pool_result_type want;
   } item_note_type;

   typedef enum logic [1:0] {
      RDY_ALWAYS, RDY_MOSTLY, RDY_SELDOM, RDY_PATTERN
   } ready_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // pool model state and register copies
   logic [31:0]       pool_life [MAX_PARTICLES];
   logic              pool_live [MAX_PARTICLES];
   logic [ACC_W-1:0]  spawn_acc = '0;
   int unsigned       live_total = 0;
   logic [31:0]       cfg_interval = SPAWN_INTERVAL_RST;
   logic [LIFE_W-1:0] cfg_lifetime = DEFAULT_LIFETIME_RST;
   logic              cfg_paused = 1'b0;
   logic              cfg_emit = 1'b1;

   item_note_type   note_q[$];
   pool_result_type pending_counts[$];
   int              error_count = 0;
   int              results_seen = 0;
   int              items_sent = 0;
   int              burst_left = 0;
   int              quiet_cycles = 0;
   bit              holdoff_req = 1'b0;

   // kind      register              op        arg            typed  act    spn    exp   full
   plan_row_type plan [NUM_ROWS] = '{
      '{ROW_ITEM, NO_REG,              OP_TICK,  32'd0,         1'b1, 7'd0,  7'd0,  7'd0,  1'b0},
      '{ROW_ITEM, NO_REG,              OP_CLEAR, 32'd0,         1'b1, 7'd0,  7'd0,  7'd0,  1'b0},
      '{ROW_ITEM, NO_REG,              OP_TICK,  32'd200000,    1'b1, 7'd0,  7'd0,  7'd0,  1'b0},
      '{ROW_ITEM, NO_REG,              OP_TICK,  32'd1,         1'b1, 7'd1,  7'd1,  7'd0,  1'b0},
      '{ROW_ITEM, NO_REG,              OP_TICK,  32'hFFFF_FFFF, 1'b1, 7'd64, 7'd64, 7'd1,  1'b1},
      '{ROW_ITEM, NO_REG,              OP_TICK,  32'd0,         1'b1, 7'd64, 7'd0,  7'd0,  1'b1},
      '{ROW_REG,  REG_PAUSED,          OP_TICK,  32'd1,         1'b0, 7'd0,  7'd0,  7'd0,  1'b0},
      '{ROW_ITEM, NO_REG,              OP_TICK,  32'hFFFF_FFFF, 1'b1, 7'd64, 7'd0,  7'd0,  1'b1},
      '{ROW_ITEM, NO_REG,              OP_CLEAR, 32'd0,         1'b1, 7'd0,  7'd0,  7'd0,  1'b0},
      '{ROW_REG,  REG_PAUSED,          OP_TICK,  32'd0,         1'b0, 7'd0,  7'd0,  7'd0,  1'b0},
      '{ROW_REG,  REG_EMITTER_ENABLED, OP_TICK,  32'd0,         1'b0, 7'd0,  7'd0,  7'd0,  1'b0},
      '{ROW_ITEM, NO_REG,              OP_TICK,  32'hFFFF_FFFF, 1'b1, 7'd0,  7'd0,  7'd0,  1'b0},
      '{ROW_REG,  REG_EMITTER_ENABLED, OP_TICK,  32'd1,         1'b0, 7'd0,  7'd0,  7'd0,  1'b0},
      '{ROW_REG,  REG_SPAWN_INTERVAL,  OP_TICK,  32'd0,         1'b0, 7'd0,  7'd0,  7'd0,  1'b0},
      '{ROW_REG,  REG_DEFAULT_LIFETIME, OP_TICK, 32'd0,         1'b0, 7'd0,  7'd0,  7'd0,  1'b0},
      '{ROW_ITEM, NO_REG,              OP_TICK,  32'd3,         1'b1, 7'd64, 7'd64, 7'd0,  1'b1},
      '{ROW_ITEM, NO_REG,              OP_TICK,  32'd0,         1'b1, 7'd0,  7'd0,  7'd64, 1'b0},
      '{ROW_REG,  REG_DEFAULT_LIFETIME, OP_TICK, 32'h7FFF_FFFF, 1'b0, 7'd0,  7'd0,  7'd0,  1'b0},
      '{ROW_REG,  REG_SPAWN_INTERVAL,  OP_TICK,  32'hFFFF_FFFF, 1'b0, 7'd0,  7'd0,  7'd0,  1'b0},
      '{ROW_ITEM, NO_REG,              OP_TICK,  32'hFFFF_FFFF, 1'b0, 7'd0,  7'd0,  7'd0,  1'b0},
      '{ROW_ITEM, NO_REG,              OP_TICK,  32'h8000_0000, 1'b0, 7'd0,  7'd0,  7'd0,  1'b0},
      '{ROW_REG,  REG_SPAWN_INTERVAL,  OP_TICK,  32'd1,         1'b0, 7'd0,  7'd0,  7'd0,  1'b0},
      '{ROW_REG,  REG_DEFAULT_LIFETIME, OP_TICK, 32'd1,         1'b0, 7'd0,  7'd0,  7'd0,  1'b0},
      '{ROW_ITEM, NO_REG,              OP_TICK,  32'd2,         1'b0, 7'd0,  7'd0,  7'd0,  1'b0},
      '{ROW_ITEM, NO_REG,              OP_TICK,  32'd1,         1'b0, 7'd0,  7'd0,  7'd0,  1'b0},
      '{ROW_ITEM, NO_REG,              OP_TICK,  32'h5555_5555, 1'b0, 7'd0,  7'd0,  7'd0,  1'b0},
      '{ROW_ITEM, NO_REG,              OP_CLEAR, 32'hAAAA_AAAA, 1'b1, 7'd0,  7'd0,  7'd0,  1'b0},
      '{ROW_ITEM, NO_REG,              OP_TICK,  32'hAAAA_AAAA, 1'b0, 7'd0,  7'd0,  7'd0,  1'b0}
   };

   particle_pool_lifetime_emitter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   initial begin
      for (int i = 0; i < MAX_PARTICLES; i++) begin
         pool_live[i] = 1'b0;
         pool_life[i] = '0;
      end
   end

   task automatic report(string field, int got, int want);
      $display("mismatch in result %0d, %s: got %0d, expected %0d",
               results_seen, field, got, want);
      error_count++;
   endtask

   task automatic apply_reg(reg_index_type idx, logic [31:0] value);
      case (idx)
         REG_SPAWN_INTERVAL:   cfg_interval = value;
         REG_DEFAULT_LIFETIME: cfg_lifetime = value[LIFE_W-1:0];
         REG_PAUSED:           cfg_paused = value[0];
         REG_EMITTER_ENABLED:  cfg_emit = value[0];
         default: ;
      endcase
   endtask

   // One item through the pool: a clear empties it; a running tick does the expiry sweep first, then the spawner.
   function automatic pool_result_type advance_pool(op_type op, logic [31:0] elapsed);
      pool_result_type res;
      logic [63:0]     step;
      logic [63:0]     total;
      logic [63:0]     chances;
      int unsigned     n_new;
      int unsigned     n_gone;
      res = '0;
      n_new = 0;
      n_gone = 0;
      if (op == OP_CLEAR) begin
         for (int i = 0; i < MAX_PARTICLES; i++) pool_live[i] = 1'b0;
         live_total = 0;
      end else if (!cfg_paused) begin
         for (int i = 0; i < MAX_PARTICLES; i++) begin
            if (pool_live[i]) begin
               if (pool_life[i] <= elapsed) begin
                  pool_live[i] = 1'b0;
                  live_total--;
                  n_gone++;
               end else begin
                  pool_life[i] = pool_life[i] - elapsed;
               end
            end
         end
         if (cfg_emit) begin
            step = (cfg_interval == 32'd0) ? 64'd1 : {32'd0, cfg_interval};
            total = {31'd0, spawn_acc} + {32'd0, elapsed};
            if (total > ACC_CEIL) total = ACC_CEIL;
            chances = (total > step) ? (total - 64'd1) / step : 64'd0;
            total = total - chances * step;
            spawn_acc = total[ACC_W-1:0];
            // spawn opportunities beyond the free slots are dropped
            for (int i = 0; i < MAX_PARTICLES; i++) begin
               if (!pool_live[i] && {32'd0, n_new} < chances) begin
                  pool_live[i] = 1'b1;
                  pool_life[i] = {1'b0, cfg_lifetime};
                  live_total++;
                  n_new++;
               end
            end
         end
      end
      res.active_count = live_total[OUT_W-1:0];
      res.spawned      = n_new[OUT_W-1:0];
      res.expired      = n_gone[OUT_W-1:0];
      res.all_active   = (live_total >= MAX_PARTICLES);
      return res;
   endfunction

   function automatic logic [31:0] draw_upto(logic [63:0] span);
      return $urandom_range(0, (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0]);
   endfunction

   // transfer monitor and checker
   always @(posedge clock) begin
      pool_result_type got;
      pool_result_type want;
      item_note_type   note;
      if (!reset) begin
         if (csr_valid && csr_ready) apply_reg(reg_index_type'(csr_index), csr_data);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_counts.size() == 0) begin
               report("result with nothing pending", int'(rsp_tdata), 0);
            end else begin
               want = pending_counts.pop_front();
               if (got.active_count !== want.active_count)
                  report("active_count", got.active_count, want.active_count);
               if (got.spawned !== want.spawned)
                  report("spawned", got.spawned, want.spawned);
               if (got.expired !== want.expired)
                  report("expired", got.expired, want.expired);
               if (got.all_active !== want.all_active)
                  report("all_active", got.all_active, want.all_active);
               if (got.pad !== 2'b00)
                  report("padding", got.pad, 0);
            end
            results_seen++;
         end
         if (req_tvalid && req_tready) begin
            note = note_q.pop_front();
            want = advance_pool(op_type'(req_tuser), req_tdata);
            if (note.typed) want = note.want;
            pending_counts.push_back(want);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: ready pattern changes mode now and then; long hold-off on request
   initial begin
      ready_mode_type mode;
      int             mode_left;
      int             held;
      int unsigned    cyc;
      mode = RDY_ALWAYS;
      mode_left = 0;
      cyc = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (holdoff_req) begin
            holdoff_req = 1'b0;
            rsp_tready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode = ready_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 400);
            end
            mode_left--;
            case (mode)
               RDY_ALWAYS:  rsp_tready <= 1'b1;
               RDY_MOSTLY:  rsp_tready <= ($urandom_range(0, 3) != 0);
               RDY_SELDOM:  rsp_tready <= ($urandom_range(0, 3) == 0);
               default:     rsp_tready <= ((cyc % 7) < 3);
            endcase
         end
      end
   end

   task automatic offer_item(op_type op, logic [31:0] elapsed, item_note_type note);
      csr_valid <= 1'b0;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= elapsed;
      note_q.push_back(note);
      do @(posedge clock); while (!(req_tvalid && req_tready));
      burst_left--;
      items_sent++;
   endtask

   // stop offering and wait until every pending result has been taken
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_counts.size() != 0);
   endtask

   // leaves csr_valid high; the next item lowers it
   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
   endtask

   initial begin
      plan_row_type      row;
      item_note_type     note;
      bit                last_was_item;
      int                phase;
      int                n_items;
      logic [31:0]       drv_interval;
      logic [LIFE_W-1:0] drv_lifetime;
      logic [31:0]       data;
      logic [31:0]       elapsed;
      logic [63:0]       span;
      op_type            op;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      last_was_item = 1'b0;
      for (int r = 0; r < NUM_ROWS; r++) begin
         row = plan[r];
         if (row.kind == ROW_REG) begin
            if (last_was_item) drain();
            write_reg(row.index, row.arg);
         end else begin
            note = '0;
            note.typed = row.typed;
            note.want.active_count = row.want_active;
            note.want.spawned      = row.want_spawned;
            note.want.expired      = row.want_expired;
            note.want.all_active   = row.want_full;
            offer_item(row.op, row.arg, note);
         end
         last_was_item = (row.kind == ROW_ITEM);
      end

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         drain();

         case ($urandom_range(0, 6))
            0:       drv_interval = $urandom_range(0, 1);
            1:       drv_interval = $urandom_range(2, 64);
            2:       drv_interval = $urandom;
            3:       drv_interval = 32'hFFFF_FFFF;
            default: drv_interval = $urandom_range(500, 300000);
         endcase
         case ($urandom_range(0, 5))
            0:       drv_lifetime = LIFE_W'($urandom_range(0, 1));
            1:       drv_lifetime = LIFE_W'($urandom_range(1, 200));
            2:       drv_lifetime = 31'h7FFF_FFFF;
            3:       drv_lifetime = LIFE_W'($urandom);
            default: begin
               span = ({32'd0, drv_interval} + 64'd1) * $urandom_range(1, 90);
               drv_lifetime = (span > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : span[LIFE_W-1:0];
            end
         endcase
         write_reg(REG_SPAWN_INTERVAL, drv_interval);
         data = $urandom;
         data[LIFE_W-1:0] = drv_lifetime;
         write_reg(REG_DEFAULT_LIFETIME, data);
         if (phase == 0 || $urandom_range(0, 1) == 0) begin
            data = $urandom;
            data[0] = ($urandom_range(0, 7) == 0);
            write_reg(REG_PAUSED, data);
         end
         if (phase == 0 || $urandom_range(0, 1) == 0) begin
            data = $urandom;
            data[0] = ($urandom_range(0, 5) != 0);
            write_reg(REG_EMITTER_ENABLED, data);
         end

         n_items = $urandom_range(40, 140);
         for (int k = 0; k < n_items; k++) begin
            // receiver holds off while items keep coming, so the input backs up
            if (phase == 1 && k == 3) begin
               holdoff_req = 1'b1;
               burst_left = 24;
            end
            op = ($urandom_range(0, 19) == 0) ? OP_CLEAR : OP_TICK;
            case ($urandom_range(0, 9))
               0:       elapsed = 32'd0;
               1:       elapsed = $urandom_range(0, 15);
               2:       elapsed = $urandom;
               3:       elapsed = 32'hFFFF_FFFF;
               4, 5:    elapsed = draw_upto({33'd0, drv_lifetime} / 4 + 64'd1);
               default: elapsed = draw_upto({32'd0, drv_interval} * 2 + 64'd1);
            endcase
            offer_item(op, elapsed, '0);
         end
         phase++;
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
